[rtl/core/section_record_deframer_core_assert.svh]
// Assertion macros for the section record deframer.
// Used by the top level only; needs clk and rst in scope.
`ifndef SECTION_RECORD_DEFRAMER_CORE_ASSERT_SVH
`define SECTION_RECORD_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication check
`define SRD_CHECK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication check
`define SRD_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

[rtl/core/srd_pkg.sv]
// Shared types and codes for the section record deframer.
// No dependencies.
package srd_pkg;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_COOKIE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_COOKIE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_TYPE      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LENGTH  = 2'd3;

  // Minimum header size in bytes
  localparam logic [31:0] HDR_BYTES = 32'd8;

  typedef enum logic [2:0] {
    EV_HEADER  = 3'd0,
    EV_PAYLOAD = 3'd1,
    EV_EMPTY   = 3'd2,
    EV_DONE    = 3'd3,
    EV_ERROR   = 3'd4
  } event_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_BAD_GLOBAL = 3'd1,
    ERR_TRUNCATED  = 3'd2,
    ERR_COOKIE     = 3'd3,
    ERR_END_NONEMP = 3'd4,
    ERR_TRAILING   = 3'd5
  } err_t;

  typedef struct packed {
    logic [31:0] global_cookie;
    logic [15:0] inner_cookie;
    logic [15:0] end_type;
    logic [31:0] total_length;
  } cfg_t;

  // Request held in the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       first_byte;
  } in_req_t;

  typedef struct packed {
    event_t      event_res;
    logic [7:0]  payload_byte;
    logic [15:0] section_type;
    logic        section_last;
    err_t        error_code;
  } result_t;

endpackage

[rtl/core/srd_cfg_regs.sv]
// Configuration register file for the section record deframer.
// Depends on srd_pkg.
module srd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [srd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srd_pkg::CFG_DATA_W-1:0] cfg_data,
  output srd_pkg::cfg_t                  cfg
);
  import srd_pkg::*;

  cfg_t regs;

  // Decode write index
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GLOBAL_COOKIE: regs.global_cookie <= cfg_data;
        REG_INNER_COOKIE:  regs.inner_cookie  <= cfg_data[15:0];
        REG_END_TYPE:      regs.end_type      <= cfg_data[15:0];
        REG_TOTAL_LENGTH:  regs.total_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

[rtl/core/srd_in_stage.sv]
// Input register of the deframer: holds one request until the parser takes it.
// Depends on srd_pkg.
module srd_in_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       data_byte,
  input  logic             first_byte,
  input  logic             take,
  output srd_pkg::in_req_t req
);
  import srd_pkg::*;

  in_req_t held;
  logic    accept;

  // Full and not drained this cycle: hold off the sender
  assign in_stall = held.valid && !take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
    end else if (accept) begin
      held.valid <= 1'b1;
    end else if (take) begin
      held.valid <= 1'b0;
    end
    if (accept) begin
      held.data_byte  <= data_byte;
      held.first_byte <= first_byte;
    end
  end

  assign req = held;

endmodule

[rtl/core/srd_parser.sv]
// Parse state machine and result register of the deframer.
// Depends on srd_pkg.
module srd_parser (
  input  logic              clk,
  input  logic              rst,
  input  srd_pkg::cfg_t     cfg,
  input  srd_pkg::in_req_t  req,
  output logic              take,
  output logic              out_valid,
  input  logic              out_stall,
  output srd_pkg::result_t  res
);
  import srd_pkg::*;

  typedef enum logic [1:0] {
    PH_GLOBAL,
    PH_SECTION,
    PH_PAYLOAD,
    PH_DONE
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  header_count, header_count_next;
  logic [63:0] header_shift, header_shift_next;
  logic [31:0] bytes_left_total, bytes_left_total_next;
  logic [31:0] bytes_left_section, bytes_left_section_next;
  logic [15:0] current_type, current_type_next;
  result_t     res_reg, res_next;

  // View of state after an optional restart
  phase_t      ph;
  logic [2:0]  cnt;
  logic [63:0] shift;
  logic [31:0] total, total_dec, sec;
  logic [15:0] ctype;
  logic [63:0] hdr;
  logic [31:0] sec_len;
  logic [15:0] sec_type, sec_cookie;

  // Output register free or draining this cycle
  assign take = req.valid && (!out_valid || !out_stall);

  always_comb begin
    ph    = req.first_byte ? PH_GLOBAL : phase;
    cnt   = req.first_byte ? 3'd0 : header_count;
    shift = (req.first_byte || cnt == 3'd0) ? 64'd0 : header_shift;
    total = req.first_byte ? cfg.total_length : bytes_left_total;
    sec   = req.first_byte ? 32'd0 : bytes_left_section;
    ctype = req.first_byte ? 16'd0 : current_type;

    total_dec = (total != 32'd0) ? total - 32'd1 : total;
    // Full header once the eighth byte lands
    hdr        = {req.data_byte, shift[55:0]};
    sec_len    = hdr[31:0];
    sec_type   = hdr[47:32];
    sec_cookie = hdr[63:48];

    phase_next              = ph;
    header_count_next       = cnt;
    header_shift_next       = shift;
    bytes_left_total_next   = total;
    bytes_left_section_next = sec;
    current_type_next       = ctype;
    res_next                = '{EV_HEADER, 8'd0, 16'd0, 1'b0, ERR_NONE};

    unique case (ph)
      PH_GLOBAL: begin
        if (cnt == 3'd0 && total < HDR_BYTES) begin
          phase_next = PH_DONE;
          res_next   = '{EV_ERROR, 8'd0, 16'd0, 1'b0, ERR_BAD_GLOBAL};
        end else begin
          header_shift_next[cnt*8 +: 8] = req.data_byte;
          header_count_next     = cnt + 3'd1;
          bytes_left_total_next = total_dec;
          if (cnt == 3'd7) begin
            if (hdr[31:0] != 32'd0 || hdr[63:32] != cfg.global_cookie) begin
              phase_next = PH_DONE;
              res_next   = '{EV_ERROR, 8'd0, 16'd0, 1'b0, ERR_BAD_GLOBAL};
            end else begin
              phase_next = PH_SECTION;
            end
          end
        end
      end
      PH_SECTION: begin
        if (cnt == 3'd0 && total == 32'd0) begin
          // Image ended on a section boundary
          phase_next = PH_DONE;
          res_next   = '{EV_DONE, 8'd0, 16'd0, 1'b0, ERR_NONE};
        end else if (cnt == 3'd0 && total < HDR_BYTES) begin
          phase_next = PH_DONE;
          res_next   = '{EV_ERROR, 8'd0, 16'd0, 1'b0, ERR_TRAILING};
        end else begin
          header_shift_next[cnt*8 +: 8] = req.data_byte;
          header_count_next     = cnt + 3'd1;
          bytes_left_total_next = total_dec;
          if (cnt == 3'd7) begin
            if (total_dec < sec_len) begin
              phase_next = PH_DONE;
              res_next   = '{EV_ERROR, 8'd0, 16'd0, 1'b0, ERR_TRUNCATED};
            end else if (sec_cookie != cfg.inner_cookie) begin
              phase_next = PH_DONE;
              res_next   = '{EV_ERROR, 8'd0, 16'd0, 1'b0, ERR_COOKIE};
            end else if (sec_type == cfg.end_type) begin
              phase_next = PH_DONE;
              if (sec_len != 32'd0) begin
                res_next = '{EV_ERROR, 8'd0, 16'd0, 1'b0, ERR_END_NONEMP};
              end else begin
                res_next = '{EV_DONE, 8'd0, 16'd0, 1'b0, ERR_NONE};
              end
            end else begin
              current_type_next = sec_type;
              if (sec_len == 32'd0) begin
                res_next = '{EV_EMPTY, 8'd0, sec_type, 1'b0, ERR_NONE};
              end else begin
                bytes_left_section_next = sec_len;
                phase_next              = PH_PAYLOAD;
              end
            end
          end
        end
      end
      PH_PAYLOAD: begin
        bytes_left_total_next = total_dec;
        if (sec <= 32'd1) begin
          bytes_left_section_next = 32'd0;
          header_count_next       = 3'd0;
          phase_next              = PH_SECTION;
          res_next = '{EV_PAYLOAD, req.data_byte, ctype, 1'b1, ERR_NONE};
        end else begin
          bytes_left_section_next = sec - 32'd1;
          res_next = '{EV_PAYLOAD, req.data_byte, ctype, 1'b0, ERR_NONE};
        end
      end
      PH_DONE: begin
        // Ignore bytes until a restart
        phase_next = PH_DONE;
      end
      default: phase_next = PH_DONE;
    endcase
  end

  // State and result register advance together
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_GLOBAL;
      header_count       <= 3'd0;
      header_shift       <= 64'd0;
      bytes_left_total   <= 32'd0;
      bytes_left_section <= 32'd0;
      current_type       <= 16'd0;
      out_valid          <= 1'b0;
    end else begin
      if (take) begin
        phase              <= phase_next;
        header_count       <= header_count_next;
        header_shift       <= header_shift_next;
        bytes_left_total   <= bytes_left_total_next;
        bytes_left_section <= bytes_left_section_next;
        current_type       <= current_type_next;
        out_valid          <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (take) begin
      res_reg <= res_next;
    end
  end

  assign res = res_reg;

endmodule

[rtl/core/section_record_deframer_core.sv]
// Section record deframer: top level.
// Depends on srd_pkg, srd_cfg_regs, srd_in_stage, srd_parser and the assert header.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one image byte per request;
//   first_byte set restarts parsing with that byte as image byte zero.
//   Output channel (out_valid/out_stall) returns exactly one result per input
//   request: event, payload byte, section type, last flag and error code.
//   Config port (cfg_we/cfg_index/cfg_data) writes global_cookie, inner_cookie,
//   end_type and total_length; total_length is sampled on a restart.
// Timing:
//   out_valid rises once the request has passed the input register and the
//   parse state update has loaded the result register. Throughput is one
//   byte per cycle while out_stall is low; the parse state machine updates
//   once per byte.
// Reset (rst, synchronous): clears config, parse state and the valid flags of both registers.
// Stall: while out_stall holds, the result stays put; one more byte is taken
//   into the input register, then in_stall rises until the result drains.
module section_record_deframer_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [srd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     data_byte,
  input  logic                           first_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     event_res,
  output logic [7:0]                     payload_byte,
  output logic [15:0]                    section_type,
  output logic                           section_last,
  output logic [2:0]                     error_code
);
  import srd_pkg::*;

  cfg_t    cfg;
  in_req_t req;
  result_t res;
  logic    take;

  srd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  srd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .first_byte (first_byte),
    .take       (take),
    .req        (req)
  );

  srd_parser u_parse (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (req),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign event_res    = res.event_res;
  assign payload_byte = res.payload_byte;
  assign section_type = res.section_type;
  assign section_last = res.section_last;
  assign error_code   = res.error_code;

`include "section_record_deframer_core_assert.svh"

  // Error code present exactly on error events
  `SRD_CHECK_NOW(a_err_match, out_valid,
    (event_res == EV_ERROR) == (error_code != ERR_NONE))
  // Payload fields only on payload events
  `SRD_CHECK_NOW(a_payload_only, out_valid && event_res != EV_PAYLOAD,
    payload_byte == 8'd0 && section_last == 1'b0)
  // A held result is never overwritten by the parser
  `SRD_CHECK_NOW(a_no_overwrite, out_valid && out_stall, !take)
  // An accepted byte always lands in the input register
  `SRD_CHECK_NEXT(a_in_lands, in_valid && !in_stall, req.valid)

endmodule
